@@ hw/rtl/utf8_encoding_detector_assert.svh @@
// Assertion macros shared by the UTF-8 detector checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef UTF8_ENCODING_DETECTOR_ASSERT_SVH
`define UTF8_ENCODING_DETECTOR_ASSERT_SVH

// Checked on every clock edge outside reset.
`define U8D_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define U8D_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ hw/rtl/utf8d_pkg.sv @@
// Types and byte-range constants for the UTF-8 encoding detector.
// No dependencies; imported by utf8d_step and the top level.
package utf8d_pkg;

    localparam logic [7:0] CONT_LOW = 8'h80;
    localparam logic [7:0] LEAD_LOW = 8'hC0;
    localparam logic [7:0] LEAD_3   = 8'hE0;
    localparam logic [7:0] LEAD_4   = 8'hF0;
    localparam logic [7:0] LEAD_5   = 8'hF8;
    localparam logic [7:0] LEAD_6   = 8'hFC;
    localparam logic [7:0] LEAD_BAD = 8'hFE;

    typedef enum logic [1:0] {
        VERDICT_ASCII   = 2'd0,
        VERDICT_MULTI   = 2'd1,
        VERDICT_INVALID = 2'd2
    } t_verdict;

    typedef struct packed {
        logic [2:0] pending;   // continuation bytes still expected
        logic       multi;     // a byte of 0x80 or above was seen
        logic       invalid;   // sticky error
    } t_scan_state;

    localparam t_scan_state SCAN_IDLE = '{pending: 3'd0, multi: 1'b0, invalid: 1'b0};

endpackage

@@ hw/rtl/utf8d_step.sv @@
// Single-byte scan step: next scan state and buffer verdict for one byte.
// Depends on utf8d_pkg.
module utf8d_step
    import utf8d_pkg::*;
(
    input  logic [7:0]  i_byte,
    input  t_scan_state i_state,
    output t_scan_state o_state,
    output t_verdict    o_verdict
);

    logic       is_cont;
    logic [2:0] lead_count;

    assign is_cont = (i_byte >= CONT_LOW) && (i_byte < LEAD_LOW);

    always_comb begin
        if (i_byte < LEAD_3) begin
            lead_count = 3'd1;
        end else if (i_byte < LEAD_4) begin
            lead_count = 3'd2;
        end else if (i_byte < LEAD_5) begin
            lead_count = 3'd3;
        end else if (i_byte < LEAD_6) begin
            lead_count = 3'd4;
        end else begin
            lead_count = 3'd5;
        end
    end

    always_comb begin
        o_state = i_state;
        if (i_state.invalid) begin
            o_state = i_state;  // bytes after an error are ignored
        end else if (i_state.pending != 3'd0) begin
            if (is_cont) begin
                o_state.pending = i_state.pending - 3'd1;
            end else begin
                o_state.invalid = 1'b1;
            end
        end else if (i_byte >= CONT_LOW) begin
            o_state.multi = 1'b1;
            if (is_cont || (i_byte >= LEAD_BAD)) begin
                o_state.invalid = 1'b1;
            end else begin
                o_state.pending = lead_count;
            end
        end
    end

    always_comb begin
        if (o_state.invalid) begin
            o_verdict = VERDICT_INVALID;
        end else if (o_state.multi) begin
            o_verdict = VERDICT_MULTI;
        end else begin
            o_verdict = VERDICT_ASCII;
        end
    end

endmodule

@@ hw/rtl/utf8_encoding_detector.sv @@
// UTF-8 encoding detector, top level. Uses utf8d_pkg and utf8d_step.
// Throughput: one byte per cycle, sustained, while the result side keeps up.
// After the last byte is taken, its verdict passes the input register, then the result
// register, before o_valid rises; a stalled verdict holds the last byte.
// Reset: synchronous, active low; clears scan state and both valid flags.
module utf8_encoding_detector
    import utf8d_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // byte channel
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    // verdict channel
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_verdict
);

    // Input register: one byte item waiting to be scanned.
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;

    // Scan state across the current buffer.
    t_scan_state r_state;
    t_scan_state n_state;

    // Result register.
    logic        r_out_valid;
    t_verdict    r_verdict;

    t_scan_state step_state;
    t_verdict    step_verdict;
    logic        out_busy;
    logic        advance;
    logic        accept;

    utf8d_step u_step (
        .i_byte    (r_in_byte),
        .i_state   (r_state),
        .o_state   (step_state),
        .o_verdict (step_verdict)
    );

    // The result register is busy only while a verdict sits there and is stalled.
    assign out_busy = r_out_valid && i_stall;
    // A non-last byte never needs the result register, so it always moves on.
    assign advance  = r_in_valid && !(r_in_last && out_busy);
    assign o_stall  = r_in_valid && !advance;
    assign accept   = i_valid && !o_stall;

    // Last byte closes the buffer: state goes back to idle for the next one.
    always_comb begin
        n_state = r_state;
        if (advance) begin
            n_state = r_in_last ? SCAN_IDLE : step_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SCAN_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Result register loads on a last byte, drains when not stalled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_last) begin
            r_verdict <= step_verdict;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_verdict = r_verdict;

endmodule

@@ hw/rtl/utf8d_checker.sv @@
// Port-level checks for the UTF-8 encoding detector, bound to the top level.
// Depends on utf8_encoding_detector_assert.svh.
module utf8d_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [1:0] o_verdict
);

`include "utf8_encoding_detector_assert.svh"

    // verdict code 3 is never produced
    `U8D_ASSERT(a_verdict_code, o_valid |-> (o_verdict != 2'd3), "verdict code out of range")
    // a stalled verdict holds
    `U8D_ASSERT(a_out_hold, o_valid && i_stall |=> o_valid && $stable(o_verdict), "stalled verdict changed")
    // byte side stalls only behind a stalled verdict
    `U8D_ASSERT(a_stall_cause, o_stall |-> o_valid && i_stall, "byte stall without stalled verdict")
    // reset empties the result register
    `U8D_ASSERT_ALWAYS(a_reset_clear, !i_rst_n |=> !o_valid, "verdict valid after reset")

endmodule

bind utf8_encoding_detector utf8d_checker u_utf8d_checker (.*);

@@ tb/tb.sv @@
// Self-checking testbench for utf8_encoding_detector: directed table, then random buffers.
// Depends on utf8d_pkg and detector RTL; verdicts from typed rows or a byte-scan predictor.
`timescale 1ns / 100ps

module tb;
    import utf8d_pkg::*;

    localparam int RAND_ITEMS  = 1250;     // random bytes to send after the table
    localparam int CYCLE_LIMIT = 250000;   // generous watchdog, well above the slowest run
    localparam int DIR_ROWS    = 25;

    // buffer flavours for the random part
    typedef enum int {
        BUF_ASCII,   // plain 7-bit text
        BUF_CLEAN,   // well-formed text with multibyte sequences
        BUF_NOISY    // stray bytes, bad leads and broken sequences mixed in
    } t_buf_kind;

    // one row of the directed table; want is only used where typed is set
    typedef struct {
        logic [7:0] b;
        logic       last;
        bit         typed;
        t_verdict   want;
    } t_dir_row;

    // DUT ports; the inputs are known from time zero
    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_valid     = 1'b0;
    logic [7:0] i_data_byte = 8'h00;
    logic       i_last_byte = 1'b0;
    logic       i_stall     = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [1:0] o_verdict;

    // predictor state: open continuations, multibyte seen, sticky error
    logic [2:0] open_conts = 3'd0;
    logic       multi_seen = 1'b0;
    logic       bad_seen   = 1'b0;

    t_verdict   verdict_q[$];    // verdicts owed by the DUT, oldest first
    logic [7:0] text_q[$];       // current random buffer
    int         err_cnt    = 0;
    int         burst_left = 0;  // items left in the current sender burst
    int         cycle_cnt  = 0;

    // receiver stall pattern
    int         stall_mode = 0;
    int         mode_left  = 0;
    t_verdict   got_want;

    // Directed items. Single-byte buffers carry their verdict; multi-byte
    // buffers are left to the predictor.
    t_dir_row dir_tab [DIR_ROWS] = '{
        '{8'h00,    1'b1, 1'b1, VERDICT_ASCII},    // lowest byte
        '{8'h7F,    1'b1, 1'b1, VERDICT_ASCII},    // top of ASCII
        '{8'hFF,    1'b1, 1'b1, VERDICT_INVALID},  // highest byte, bad lead
        '{LEAD_BAD, 1'b1, 1'b1, VERDICT_INVALID},  // 0xFE is never a lead
        '{CONT_LOW, 1'b1, 1'b1, VERDICT_INVALID},  // stray continuation
        '{LEAD_LOW, 1'b1, 1'b1, VERDICT_MULTI},    // lone lead at the end
        // legacy six-byte sequence, full
        '{8'hFD,    1'b0, 1'b0, VERDICT_ASCII},
        '{8'h80,    1'b0, 1'b0, VERDICT_ASCII},
        '{8'h80,    1'b0, 1'b0, VERDICT_ASCII},
        '{8'h80,    1'b0, 1'b0, VERDICT_ASCII},
        '{8'h80,    1'b0, 1'b0, VERDICT_ASCII},
        '{8'hBF,    1'b1, 1'b0, VERDICT_ASCII},
        // ASCII byte inside a three-byte sequence
        '{LEAD_3,   1'b0, 1'b0, VERDICT_ASCII},
        '{8'h80,    1'b0, 1'b0, VERDICT_ASCII},
        '{8'h41,    1'b1, 1'b0, VERDICT_ASCII},
        // four-byte sequence cut short by the end of the buffer
        '{LEAD_4,   1'b0, 1'b0, VERDICT_ASCII},
        '{8'h80,    1'b1, 1'b0, VERDICT_ASCII},
        // error first, later bytes must not matter
        '{8'hBF,    1'b0, 1'b0, VERDICT_ASCII},
        '{8'hC2,    1'b0, 1'b0, VERDICT_ASCII},
        '{8'h41,    1'b1, 1'b0, VERDICT_ASCII},
        // five-byte sequence, complete on the last byte
        '{LEAD_5,   1'b0, 1'b0, VERDICT_ASCII},
        '{8'h80,    1'b0, 1'b0, VERDICT_ASCII},
        '{8'hA5,    1'b0, 1'b0, VERDICT_ASCII},
        '{8'h9C,    1'b0, 1'b0, VERDICT_ASCII},
        '{8'hBF,    1'b1, 1'b0, VERDICT_ASCII}
    };

    utf8_encoding_detector dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_verdict   (o_verdict)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Byte scan: updates the predictor state for one accepted item and, on
    // the last byte of a buffer, hands back the verdict and clears the state.
    task automatic scan_byte(input logic [7:0] b, input logic last,
                             output bit has_v, output t_verdict v);
        has_v = 1'b0;
        v     = VERDICT_ASCII;
        if (!bad_seen) begin
            if (open_conts != 3'd0) begin
                // inside a sequence only 0x80..0xBF may follow
                if (b >= CONT_LOW && b < LEAD_LOW)
                    open_conts = open_conts - 3'd1;
                else
                    bad_seen = 1'b1;
            end else if (b >= CONT_LOW) begin
                multi_seen = 1'b1;
                if (b < LEAD_LOW || b >= LEAD_BAD)
                    bad_seen = 1'b1;       // stray continuation or 0xFE/0xFF
                else if (b < LEAD_3)
                    open_conts = 3'd1;
                else if (b < LEAD_4)
                    open_conts = 3'd2;
                else if (b < LEAD_5)
                    open_conts = 3'd3;
                else if (b < LEAD_6)
                    open_conts = 3'd4;
                else
                    open_conts = 3'd5;
            end
        end
        if (last) begin
            has_v = 1'b1;
            if (bad_seen)
                v = VERDICT_INVALID;
            else if (multi_seen)
                v = VERDICT_MULTI;
            // an open sequence at the end is simply dropped
            open_conts = 3'd0;
            multi_seen = 1'b0;
            bad_seen   = 1'b0;
        end
    endtask

    // Present one item, hold it until taken, then run the predictor on it.
    // Gaps between bursts are inserted here, after the handshake.
    task automatic send_item(input logic [7:0] b, input logic last,
                             input bit typed, input t_verdict want);
        bit       has_v;
        t_verdict pv;
        int       gap;
        i_valid     <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= last;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        scan_byte(b, last, has_v, pv);
        if (has_v)
            verdict_q.push_back(typed ? want : pv);
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            // now and then a long burst with no idling at all
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 16);
        end
    endtask

    // Sender goes quiet until every owed verdict has come back.
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // A lead byte of n continuations, then either all of them or a
    // truncated run followed by a byte that cannot continue it.
    task automatic push_sequence(input bit broken);
        int n;
        int k;
        n = $urandom_range(1, 5);
        case (n)
            1: text_q.push_back(8'($urandom_range(LEAD_LOW, LEAD_3 - 1)));
            2: text_q.push_back(8'($urandom_range(LEAD_3, LEAD_4 - 1)));
            3: text_q.push_back(8'($urandom_range(LEAD_4, LEAD_5 - 1)));
            4: text_q.push_back(8'($urandom_range(LEAD_5, LEAD_6 - 1)));
            default: text_q.push_back(8'($urandom_range(LEAD_6, LEAD_BAD - 1)));
        endcase
        k = broken ? $urandom_range(0, n - 1) : n;
        repeat (k) text_q.push_back(8'($urandom_range(CONT_LOW, LEAD_LOW - 1)));
        if (broken)
            text_q.push_back(($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 127))
                                                        : 8'($urandom_range(LEAD_LOW, 255)));
    endtask

    // Verdict side: check each taken verdict against the oldest owed one,
    // then pick the stall for the next edge. The pattern switches between
    // no stalls, light random, heavy random and a fixed duty cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (verdict_q.size() == 0) begin
                $display("%0t: verdict %0d taken, none expected", $time, o_verdict);
                err_cnt++;
            end else begin
                got_want = verdict_q.pop_front();
                if (o_verdict !== got_want) begin
                    $display("%0t: verdict mismatch, expected %0d actual %0d",
                             $time, got_want, o_verdict);
                    err_cnt++;
                end
            end
        end
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(32, 256);
        end else begin
            mode_left--;
        end
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 3) == 0);
            2: i_stall <= ($urandom_range(0, 3) != 0);
            default: i_stall <= ((cycle_cnt % 5) < 2);
        endcase
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("[utf8_encoding_detector] ERROR");
            $finish;
        end
    end

    // Stimulus: reset, directed table, random buffers, then drain and report.
    initial begin
        int        rand_sent;
        int        len_goal;
        int        r;
        bit        paused;
        t_buf_kind kind;
        rand_sent = 0;
        paused    = 1'b0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[i])
            send_item(dir_tab[i].b, dir_tab[i].last, dir_tab[i].typed, dir_tab[i].want);
        wait_drained();

        while (rand_sent < RAND_ITEMS) begin
            r = $urandom_range(0, 9);
            kind = (r < 2) ? BUF_ASCII : (r < 8) ? BUF_CLEAN : BUF_NOISY;
            // short buffers keep verdicts frequent; a few long ones too
            len_goal = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 40)
                                                    : $urandom_range(1, 12);
            text_q.delete();
            while (text_q.size() < len_goal) begin
                case (kind)
                    BUF_ASCII: text_q.push_back(8'($urandom_range(0, 127)));
                    BUF_CLEAN: begin
                        if ($urandom_range(0, 2) == 0)
                            text_q.push_back(8'($urandom_range(0, 127)));
                        else
                            push_sequence(1'b0);
                    end
                    default: begin
                        r = $urandom_range(0, 5);
                        if (r < 2)
                            text_q.push_back(8'($urandom_range(0, 127)));
                        else if (r == 2)
                            push_sequence(1'b0);
                        else if (r == 3)
                            push_sequence(1'b1);
                        else
                            text_q.push_back(8'($urandom_range(0, 255)));
                    end
                endcase
            end
            // trimming to length often leaves a sequence cut short at the end
            while (text_q.size() > len_goal)
                void'(text_q.pop_back());
            foreach (text_q[k])
                send_item(text_q[k], (k == text_q.size() - 1), 1'b0, VERDICT_ASCII);
            rand_sent += text_q.size();
            if (!paused && rand_sent >= RAND_ITEMS / 2) begin
                paused = 1'b1;
                wait_drained();
            end
        end

        wait_drained();
        if (err_cnt == 0 && verdict_q.size() == 0) begin
            $display("[utf8_encoding_detector] OK");
        end else begin
            $display("[utf8_encoding_detector] ERROR");
        end
        $finish;
    end

endmodule
